// ----- hw/rtl/huffman_code_bit_packer_unit_defines.svh -----
`ifndef HUFFMAN_CODE_BIT_PACKER_UNIT_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_UNIT_DEFINES_SVH

// checked out of reset only
`define HCBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked in and out of reset
`define HCBP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hw/rtl/hcbp_pkg.sv -----
package hcbp_pkg;

  localparam int SYM_W        = 8;
  localparam int TBL_DEPTH    = 1 << SYM_W;
  localparam int CODE_BITS    = 32;
  localparam int LEN_W        = 6;
  localparam int BYTE_BITS    = 8;
  localparam int VB_W         = 4;
  localparam int ACC_W        = CODE_BITS + BYTE_BITS;
  localparam int TOT_W        = 6;
  localparam int MAX_CODE_LEN = 32;
  localparam int LEN_LIMIT_I  = (MAX_CODE_LEN < CODE_BITS) ? MAX_CODE_LEN : CODE_BITS;
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LEN_LIMIT_I);

  // queue depth must be a power of two
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 2;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_FLUSH  = 2'd2
  } hcbp_action_e;

  // code bits are stored left aligned, first bit at the msb
  typedef struct packed {
    logic                 flush;
    logic [CODE_BITS-1:0] bits;
    logic [LEN_W-1:0]     len;
  } hcbp_cmd_t;

endpackage

// ----- hw/rtl/hcbp_front.sv -----
module hcbp_front
  import hcbp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           action_i,
  input  logic [SYM_W-1:0]     symbol_i,
  input  logic [CODE_BITS-1:0] code_value_i,
  input  logic [LEN_W-1:0]     code_length_i,
  output hcbp_cmd_t            cmd_o,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i
);

  logic [CODE_BITS+LEN_W-1:0] tbl_mem_q [TBL_DEPTH];
  logic [TBL_DEPTH-1:0]       ent_vld_q, ent_vld_d;
  logic [CODE_BITS+LEN_W-1:0] rd_q;
  logic                       rd_vld_q, rd_vld_d;
  logic                       s1_valid_q, s1_valid_d;
  logic                       s1_flush_q, s1_flush_d;
  logic                       accept;
  logic                       is_load, is_work;
  logic                       drop;
  logic [LEN_W-1:0]           len_sat;
  logic [LEN_W-1:0]           shamt;
  logic [CODE_BITS-1:0]       bits_left;
  logic [LEN_W-1:0]           rd_len;

  always_comb begin
    is_load = 1'b0;
    is_work = 1'b0;
    case (hcbp_action_e'(action_i))
      ACT_LOAD:   is_load = 1'b1;
      ACT_ENCODE: is_work = 1'b1;
      ACT_FLUSH:  is_work = 1'b1;
      default: begin
      end
    endcase
  end

  assign len_sat   = (code_length_i > LEN_LIMIT) ? LEN_LIMIT : code_length_i;
  assign shamt     = LEN_W'(CODE_BITS) - len_sat;
  assign bits_left = code_value_i << shamt;

  // a symbol never loaded reads as no code
  assign rd_len = rd_vld_q ? rd_q[LEN_W-1:0] : '0;
  assign drop   = !s1_flush_q && (rd_len == '0);

  assign cmd_o.flush = s1_flush_q;
  assign cmd_o.bits  = rd_q[CODE_BITS+LEN_W-1:LEN_W];
  assign cmd_o.len   = rd_len;
  assign cmd_valid_o = s1_valid_q && !drop;

  assign in_ready_o = !s1_valid_q || drop || cmd_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    ent_vld_d  = ent_vld_q;
    rd_vld_d   = rd_vld_q;
    s1_valid_d = s1_valid_q;
    s1_flush_d = s1_flush_q;
    if (in_ready_o) begin
      s1_valid_d = accept && is_work;
    end
    if (accept) begin
      rd_vld_d   = ent_vld_q[symbol_i];
      s1_flush_d = (hcbp_action_e'(action_i) == ACT_FLUSH);
      if (is_load) begin
        ent_vld_d[symbol_i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q  <= '0;
      rd_vld_q   <= 1'b0;
      s1_valid_q <= 1'b0;
      s1_flush_q <= 1'b0;
    end else begin
      ent_vld_q  <= ent_vld_d;
      rd_vld_q   <= rd_vld_d;
      s1_valid_q <= s1_valid_d;
      s1_flush_q <= s1_flush_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_load) begin
      tbl_mem_q[symbol_i] <= {bits_left, len_sat};
    end
    if (accept) begin
      rd_q <= tbl_mem_q[symbol_i];
    end
  end

endmodule

// ----- hw/rtl/hcbp_fifo.sv -----
module hcbp_fifo
  import hcbp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  hcbp_cmd_t push_cmd_i,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  output hcbp_cmd_t pop_cmd_o,
  output logic      pop_valid_o,
  input  logic      pop_ready_i
);

  hcbp_cmd_t          slot_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CW-1:0] cnt_q, cnt_d;
  logic               push, pop;

  assign push_ready_o = (cnt_q != FIFO_CW'(FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ----- hw/rtl/hcbp_back.sv -----
`include "huffman_code_bit_packer_unit_defines.svh"

module hcbp_back
  import hcbp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hcbp_cmd_t            cmd_i,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [BYTE_BITS-1:0] out_byte_o,
  output logic [VB_W-1:0]      valid_bits_o,
  output logic                 byte_present_o,
  output logic                 is_flush_o,
  output logic                 last_o
);

  localparam logic [TOT_W-1:0] FULL_TOT = TOT_W'(BYTE_BITS);
  localparam logic [TOT_W-1:0] TWO_TOT  = TOT_W'(2 * BYTE_BITS);
  localparam logic [VB_W-1:0]  FULL_VB  = VB_W'(BYTE_BITS);

  // bit stream left aligned in acc, total_q bits valid, the rest zero
  logic [ACC_W-1:0]     acc_q, acc_d;
  logic [TOT_W-1:0]     total_q, total_d;
  logic                 ovld_q, ovld_d;
  logic [BYTE_BITS-1:0] obyte_q, obyte_d;
  logic [VB_W-1:0]      ovb_q, ovb_d;
  logic                 opres_q, opres_d;
  logic                 oflush_q, oflush_d;
  logic                 olast_q, olast_d;
  logic                 slot_free;
  logic                 take;
  logic [ACC_W-1:0]     merged;
  logic [TOT_W-1:0]     tot_new;
  logic [ACC_W-1:0]     cur_acc;
  logic [TOT_W-1:0]     cur_tot;
  logic                 emit_byte;

  assign slot_free   = !ovld_q || out_ready_i;
  assign take        = cmd_valid_i && (total_q < FULL_TOT) && slot_free;
  assign cmd_ready_o = (total_q < FULL_TOT) && slot_free;

  assign merged  = acc_q | ({cmd_i.bits, {BYTE_BITS{1'b0}}} >> total_q[2:0]);
  assign tot_new = total_q + cmd_i.len;
  assign cur_acc = take ? merged : acc_q;
  assign cur_tot = take ? tot_new : total_q;

  always_comb begin
    acc_d     = acc_q;
    total_d   = total_q;
    ovld_d    = ovld_q && !out_ready_i;
    obyte_d   = obyte_q;
    ovb_d     = ovb_q;
    opres_d   = opres_q;
    oflush_d  = oflush_q;
    olast_d   = olast_q;
    emit_byte = 1'b0;
    if (take && cmd_i.flush) begin
      ovld_d   = 1'b1;
      oflush_d = 1'b1;
      olast_d  = 1'b1;
      if (total_q != '0) begin
        obyte_d = acc_q[ACC_W-1 -: BYTE_BITS];
        ovb_d   = VB_W'(total_q);
        opres_d = 1'b1;
      end else begin
        obyte_d = '0;
        ovb_d   = FULL_VB;
        opres_d = 1'b0;
      end
      acc_d   = '0;
      total_d = '0;
    end else begin
      if (slot_free && (cur_tot >= FULL_TOT)) begin
        emit_byte = 1'b1;
        ovld_d    = 1'b1;
        obyte_d   = cur_acc[ACC_W-1 -: BYTE_BITS];
        ovb_d     = FULL_VB;
        opres_d   = 1'b1;
        oflush_d  = 1'b0;
        olast_d   = (cur_tot < TWO_TOT);
        acc_d     = cur_acc << BYTE_BITS;
        total_d   = cur_tot - FULL_TOT;
      end else if (take) begin
        acc_d   = cur_acc;
        total_d = cur_tot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      total_q <= '0;
      ovld_q  <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      total_q <= total_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q  <= obyte_d;
    ovb_q    <= ovb_d;
    opres_q  <= opres_d;
    oflush_q <= oflush_d;
    olast_q  <= olast_d;
  end

  assign out_valid_o    = ovld_q;
  assign out_byte_o     = obyte_q;
  assign valid_bits_o   = ovb_q;
  assign byte_present_o = opres_q;
  assign is_flush_o     = oflush_q;
  assign last_o         = olast_q;

  // more bytes of the same symbol still wait in the accumulator
  `HCBP_ASSERT(a_not_last_has_more, emit_byte && !olast_d |=> total_q >= FULL_TOT, "byte without last but nothing left")
  `HCBP_ASSERT_ALWAYS(a_empty_acc_zero, (total_q == '0) |-> (acc_q == '0), "stale bits in empty accumulator")
  `HCBP_ASSERT(a_no_byte_is_flush, ovld_q && !opres_q |-> oflush_q && olast_q && (ovb_q == FULL_VB) && (obyte_q == '0), "bad empty flush result")

endmodule

// ----- hw/rtl/huffman_code_bit_packer_unit.sv -----
// path: table read register, then command queue, then packer output register
// input: one item per cycle while the 4-entry command queue has room
// packer: up to 4 bytes per encode, one result per flush, nothing per load
// output: one byte per cycle unless m_axis_tready stalls the single output register
// reset: code table valid flags, queue and pending bits cleared at once, all symbols
// start with no code; no clearing pass, ready right after reset
module huffman_code_bit_packer_unit
  import hcbp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // symbol[7:0], code_value[39:8], code_length[45:40], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // action[1:0]
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_byte[7:0], valid_bits[11:8], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // byte_present[0], is_flush[1]
  output logic [OUT_USER_W-1:0] m_axis_tuser,
  output logic                  m_axis_tlast
);

  hcbp_cmd_t            fr_cmd, q_cmd;
  logic                 fr_valid, fr_ready;
  logic                 q_valid, q_ready;
  logic [BYTE_BITS-1:0] out_byte;
  logic [VB_W-1:0]      valid_bits;
  logic                 byte_present, is_flush;

  hcbp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .action_i      (s_axis_tuser[1:0]),
    .symbol_i      (s_axis_tdata[SYM_W-1:0]),
    .code_value_i  (s_axis_tdata[SYM_W+CODE_BITS-1:SYM_W]),
    .code_length_i (s_axis_tdata[SYM_W+CODE_BITS+LEN_W-1:SYM_W+CODE_BITS]),
    .cmd_o         (fr_cmd),
    .cmd_valid_o   (fr_valid),
    .cmd_ready_i   (fr_ready)
  );

  hcbp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_cmd_i   (fr_cmd),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .pop_cmd_o    (q_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready)
  );

  hcbp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (q_cmd),
    .cmd_valid_i    (q_valid),
    .cmd_ready_o    (q_ready),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_byte_o     (out_byte),
    .valid_bits_o   (valid_bits),
    .byte_present_o (byte_present),
    .is_flush_o     (is_flush),
    .last_o         (m_axis_tlast)
  );

  assign m_axis_tdata = {{(OUT_DATA_W-BYTE_BITS-VB_W){1'b0}}, valid_bits, out_byte};
  assign m_axis_tuser = {is_flush, byte_present};

endmodule
